/* hdl/hmtt_pkg.sv */
// shared types, constants and helpers of the track transcoder
package hmtt_pkg;

  // results one input byte may cause, and the width of a burst count
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // marker bytes
  localparam logic [7:0] META_MARK = 8'hFF;
  localparam logic [7:0] META_END_KIND = 8'h2F;
  localparam logic [7:0] TOP_BIT = 8'h80;
  localparam logic [6:0] LOW7 = 7'h7F;

  // appended end-of-track sequence
  localparam logic [7:0] END_SEQ [4] = '{8'h00, 8'hFF, 8'h2F, 8'h00};

  // event length in bytes, status included, for commands 8x to Fx
  localparam logic [1:0] CMD_LENGTH [8] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd0};

  // meta length field width
  localparam int META_W = 28;

  typedef enum logic [2:0] {
    PH_DELTA     = 3'd0,
    PH_STATUS    = 3'd1,
    PH_META_TYPE = 3'd2,
    PH_META_LEN  = 3'd3,
    PH_META_BODY = 3'd4,
    PH_DATA      = 3'd5
  } phase_t;

  // conversion state apart from the delta accumulator
  typedef struct packed {
    phase_t              phase;
    logic [2:0]          group_count;
    logic [7:0]          running_status;
    logic [1:0]          data_left;
    logic [META_W-1:0]   meta_left;
    logic [7:0]          meta_kind;
    logic                stopped;
  } conv_state_t;

  localparam conv_state_t STATE_RESET = '{
    phase:          PH_DELTA,
    group_count:    3'd0,
    running_status: 8'h00,
    data_left:      2'd0,
    meta_left:      '0,
    meta_kind:      8'h00,
    stopped:        1'b0
  };

  // data bytes that follow a status byte
  function automatic logic [1:0] data_bytes_for(input logic [7:0] status);
    logic [1:0] n;
    n = 2'd0;
    if (status[7] && (status[7:4] != 4'hF)) begin
      n = CMD_LENGTH[status[6:4]] - 2'd1;
    end
    return n;
  endfunction

endpackage

/* hdl/hmi_to_midi_track_transcoder_top.sv */
// top level of the track transcoder: state, burst register and handshakes
//
// Takes one byte of a compact sequencer track per transfer and gives the bytes
// of a standard MIDI track body, one per output transfer. Each input byte is
// converted in the cycle it is taken, and the bytes it causes (0 to 8) are held
// in a burst register that drains one byte per cycle while out_ready is high.
// A byte with no result or one result never holds the input, so the sustained
// rate is one byte per cycle while out_ready is high; after more results the
// next byte is taken in the cycle the last of them transfers. run_last marks
// the last byte of each burst, track_end the final byte of the end-of-track
// sequence 00 FF 2F 00 appended after a byte marked last_byte. track_active
// resets to 1; write it by cfg_we / cfg_wdata only while idle (not enforced).
module hmi_to_midi_track_transcoder_top #(
  parameter int MAX_DELTA_GROUPS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       track_end
);
  import hmtt_pkg::*;

  localparam int CW = $clog2(MAX_DELTA_GROUPS + 1);
  localparam int AW = 7 * MAX_DELTA_GROUPS;

  logic                             track_active;
  conv_state_t                      st;
  conv_state_t                      st_next;
  logic [AW-1:0]                    accum;
  logic [AW-1:0]                    accum_next;
  logic [MAX_DELTA_GROUPS-1:0][7:0] emit_bytes;
  logic [CW-1:0]                    emit_count;

  logic [7:0]                       burst [MAX_RESULTS];
  logic [7:0]                       burst_next [MAX_RESULTS];
  logic [CNT_W-1:0]                 count;
  logic [CNT_W-1:0]                 count_next;
  logic [CNT_W:0]                   total;
  logic [CNT_W:0]                   pos;
  logic                             ended;
  logic                             in_xfer;
  logic                             out_xfer;

  hmtt_conv #(
    .MAX_DELTA_GROUPS(MAX_DELTA_GROUPS)
  ) u_conv (
    .st          (st),
    .accum       (accum),
    .in_byte     (in_byte),
    .last_byte   (last_byte),
    .track_active(track_active),
    .st_next     (st_next),
    .accum_next  (accum_next),
    .emit_bytes  (emit_bytes),
    .emit_count  (emit_count)
  );

  // handshakes: take a byte once the burst is empty or its last byte leaves
  assign out_valid = (count != '0);
  assign in_ready  = (count == '0) || ((count == CNT_W'(1)) && out_ready);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  // assemble the burst: converted bytes, then the end-of-track sequence
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      burst_next[i] = 8'h00;
    end
    for (int j = 0; j < MAX_DELTA_GROUPS; j++) begin
      burst_next[j] = emit_bytes[j];
    end
    if (last_byte) begin
      for (int e = 0; e < 4; e++) begin
        pos = (CNT_W + 1)'(emit_count) + (CNT_W + 1)'(e);
        if (pos < (CNT_W + 1)'(MAX_RESULTS)) begin
          burst_next[pos[CNT_W-2:0]] = END_SEQ[e];
        end
      end
    end
    total = (CNT_W + 1)'(emit_count) + (last_byte ? (CNT_W + 1)'(4) : '0);
    if (total > (CNT_W + 1)'(MAX_RESULTS)) begin
      count_next = CNT_W'(MAX_RESULTS);
    end else begin
      count_next = total[CNT_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      track_active <= 1'b1;
      st           <= STATE_RESET;
      accum        <= '0;
      count        <= '0;
    end else begin
      if (cfg_we) begin
        track_active <= cfg_wdata;
      end
      if (in_xfer) begin
        st    <= st_next;
        accum <= accum_next;
        count <= count_next;
      end else if (out_xfer) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // burst payload: load on input transfer, shift on output transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      burst <= burst_next;
      ended <= last_byte;
    end else if (out_xfer) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        burst[i] <= burst[i+1];
      end
    end
  end

  // result outputs
  assign out_byte  = burst[0];
  assign run_last  = (count == CNT_W'(1));
  assign track_end = run_last && ended;

`ifndef SYNTHESIS
  // a last byte always leaves the end-of-track sequence in the burst
  a_last_gives_end: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && last_byte) |=> (out_valid && ended && (count >= CNT_W'(4))))
    else $error("end-of-track sequence missing after last byte");

  // a track boundary leaves the converter in its reset phase
  a_boundary_reset: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && last_byte) |=> ((st.phase == PH_DELTA) && !st.stopped &&
                                (st.running_status == 8'h00) && (accum == '0)))
    else $error("conversion state not cleared at track boundary");

  // no new byte is taken while more than one result is still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (count > CNT_W'(1)) |-> !in_ready)
    else $error("input taken over a pending burst");

  // a burst shrinks by exactly one per output transfer that takes no new byte
  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && !in_xfer) |=> (count == $past(count) - CNT_W'(1)))
    else $error("burst count out of step");
`endif

endmodule

/* hdl/hmtt_conv.sv */
// per-byte conversion step: next state and the converted bytes of one input byte
module hmtt_conv #(
  parameter int MAX_DELTA_GROUPS = 4
) (
  input  hmtt_pkg::conv_state_t                 st,
  input  logic [7*MAX_DELTA_GROUPS-1:0]         accum,
  input  logic [7:0]                            in_byte,
  input  logic                                  last_byte,
  input  logic                                  track_active,
  output hmtt_pkg::conv_state_t                 st_next,
  output logic [7*MAX_DELTA_GROUPS-1:0]         accum_next,
  output logic [MAX_DELTA_GROUPS-1:0][7:0]      emit_bytes,
  output logic [$clog2(MAX_DELTA_GROUPS+1)-1:0] emit_count
);
  import hmtt_pkg::*;

  localparam int CW = $clog2(MAX_DELTA_GROUPS + 1);
  localparam int HW = $clog2(MAX_DELTA_GROUPS);
  localparam int AW = 7 * MAX_DELTA_GROUPS;

  logic [AW-1:0]               acc_add;
  logic [2:0]                  gc_add;
  logic [HW-1:0]               hi;
  logic [MAX_DELTA_GROUPS-1:0][7:0] delta_bytes;
  logic [CW-1:0]               delta_count;
  logic [META_W-1:0]           ml;
  logic [1:0]                  dl;
  conv_state_t                 st_conv;
  logic [AW-1:0]               acc_conv;

  // fold the current byte into the delta accumulator
  always_comb begin
    acc_add = accum;
    gc_add  = st.group_count;
    if (st.group_count < 3'(MAX_DELTA_GROUPS)) begin
      gc_add = st.group_count + 3'd1;
      for (int g = 0; g < MAX_DELTA_GROUPS; g++) begin
        if (st.group_count == 3'(g)) begin
          acc_add[7*g +: 7] = accum[7*g +: 7] | in_byte[6:0];
        end
      end
    end
  end

  // big-endian groups of the delta, leading zero groups suppressed
  always_comb begin
    hi = '0;
    for (int g = 1; g < MAX_DELTA_GROUPS; g++) begin
      if (acc_add[7*g +: 7] != 7'd0) begin
        hi = HW'(g);
      end
    end
    delta_bytes = '0;
    for (int g = 0; g < MAX_DELTA_GROUPS; g++) begin
      if (HW'(g) <= hi) begin
        delta_bytes[hi - HW'(g)] = {(g != 0), acc_add[7*g +: 7]};
      end
    end
    delta_count = CW'(hi) + CW'(1);
  end

  // phase sequencer
  always_comb begin
    st_conv    = st;
    acc_conv   = accum;
    emit_bytes = '0;
    emit_count = '0;
    ml         = st.meta_left;
    dl         = st.data_left;
    unique case (st.phase)
      PH_DELTA: begin
        acc_conv             = acc_add;
        st_conv.group_count  = gc_add;
        if (in_byte[7]) begin
          emit_bytes          = delta_bytes;
          emit_count          = delta_count;
          acc_conv            = '0;
          st_conv.group_count = 3'd0;
          st_conv.phase       = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (in_byte == META_MARK) begin
          st_conv.phase = PH_META_TYPE;
        end else if (in_byte[7]) begin
          st_conv.running_status = in_byte;
          emit_bytes[0]          = in_byte;
          emit_count             = CW'(1);
          dl                     = data_bytes_for(in_byte);
          st_conv.data_left      = dl;
          st_conv.phase          = (dl != 2'd0) ? PH_DATA : PH_DELTA;
        end else if (st.running_status == 8'h00) begin
          st_conv.stopped = 1'b1;
        end else begin
          emit_bytes[0] = st.running_status;
          dl            = data_bytes_for(st.running_status);
          if (dl == 2'd0) begin
            // status without data: the byte opens the next delta
            emit_count          = CW'(1);
            st_conv.phase       = PH_DELTA;
            acc_conv            = acc_add;
            st_conv.group_count = gc_add;
          end else begin
            emit_bytes[1]     = in_byte;
            emit_count        = CW'(2);
            st_conv.data_left = dl - 2'd1;
            st_conv.phase     = (dl != 2'd1) ? PH_DATA : PH_DELTA;
          end
        end
      end
      PH_META_TYPE: begin
        st_conv.meta_kind = in_byte;
        emit_bytes[0]     = META_MARK;
        emit_bytes[1]     = in_byte;
        emit_count        = CW'(2);
        st_conv.meta_left = '0;
        st_conv.phase     = PH_META_LEN;
      end
      PH_META_LEN: begin
        emit_bytes[0]     = in_byte;
        emit_count        = CW'(1);
        ml                = {st.meta_left[META_W-8:0], in_byte[6:0]};
        st_conv.meta_left = ml;
        if (!in_byte[7]) begin
          if (ml != '0) begin
            st_conv.phase = PH_META_BODY;
          end else if (st.meta_kind == META_END_KIND) begin
            st_conv.stopped = 1'b1;
          end else begin
            st_conv.phase = PH_DELTA;
          end
        end
      end
      PH_META_BODY: begin
        emit_bytes[0]     = in_byte;
        emit_count        = CW'(1);
        ml                = st.meta_left - META_W'(1);
        st_conv.meta_left = ml;
        if (ml == '0) begin
          if (st.meta_kind == META_END_KIND) begin
            st_conv.stopped = 1'b1;
          end else begin
            st_conv.phase = PH_DELTA;
          end
        end
      end
      PH_DATA: begin
        emit_bytes[0]     = in_byte;
        emit_count        = CW'(1);
        dl                = st.data_left - 2'd1;
        st_conv.data_left = dl;
        if (dl == 2'd0) begin
          st_conv.phase = PH_DELTA;
        end
      end
      default: begin
        st_conv.phase = PH_DELTA;
      end
    endcase

    // inactive or stopped track ignores the byte
    if (!track_active || st.stopped) begin
      st_conv    = st;
      acc_conv   = accum;
      emit_bytes = '0;
      emit_count = '0;
    end
  end

  // a track boundary returns everything to reset
  always_comb begin
    st_next    = st_conv;
    accum_next = acc_conv;
    if (last_byte) begin
      st_next    = STATE_RESET;
      accum_next = '0;
    end
  end

endmodule
